FILE: design/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Operation codes shared by the paged byte store.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_READ   = 2'd0;
  localparam op_t OP_WRITE  = 2'd1;
  localparam op_t OP_FLUSH  = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 8;

endpackage

`default_nettype wire

FILE: design/paged_byte_store_lru_write_back.sv
// ----------------------------------------------------------------------------
// paged_byte_store_lru_write_back
// Byte store of NUM_PAGES pages cached in NUM_FRAMES frames, LRU, write-back.
// ----------------------------------------------------------------------------
// Usage. Each transfer on the in_ channel carries one operation: read a byte,
// write a byte or flush every dirty frame. Exactly one transfer on the out_
// channel follows for each, in order. An index beyond the array is flagged
// on index_error and changes nothing; the unused operation code returns zeros.
// Flow. A hit goes from the lookup straight to the frame access and then to
// the result register; a read also waits on the registered frame memory. A
// miss adds a page load, preceded by a copy of the victim frame to the
// backing store when that frame is dirty. A flush visits every frame and
// copies each dirty one back. Each copy is a loop between the frame memory
// and the backing store, which moves one byte per cycle.
// Items are handled one at a time; in_ready is high only while the block is
// idle. A finished result waits in the output register, and the next item
// is taken meanwhile; it can only finish once that register is free.
// Reset (rst_n low, synchronous) empties every frame and restores recency
// with frame zero least recent. The backing store reads as zero until a page
// is first written back, tracked by one flag per page, so no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_byte_store_lru_write_back
  import pbs_pkg::*;
#(
  parameter int PAGE_SIZE  = 16,
  parameter int NUM_PAGES  = 64,
  parameter int NUM_FRAMES = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_operation,
  input  wire logic [IDX_W-1:0]  in_byte_index,
  input  wire logic [DATA_W-1:0] in_write_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_read_data,
  output logic                   out_was_hit,
  output logic                   out_wrote_back,
  output logic                   out_index_error
);

  // Only the first 1024 bytes can ever be addressed by a 10-bit index.
  localparam int ARRAY_BYTES = PAGE_SIZE * NUM_PAGES;
  localparam int BS_DEPTH    = (ARRAY_BYTES < 1024) ? ARRAY_BYTES : 1024;
  localparam int NPG         = (BS_DEPTH + PAGE_SIZE - 1) / PAGE_SIZE;
  localparam int BSW         = (BS_DEPTH > 1) ? $clog2(BS_DEPTH) : 1;
  localparam int PGW         = (NPG > 1) ? $clog2(NPG) : 1;
  localparam int OFFW        = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;
  localparam int CW          = $clog2(PAGE_SIZE + 1);
  localparam int FM_DEPTH    = NUM_FRAMES * PAGE_SIZE;
  localparam int FMW         = (FM_DEPTH > 1) ? $clog2(FM_DEPTH) : 1;
  localparam int FRW         = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  // Reciprocal for the page split: exact for every 10-bit index.
  localparam int  RSH        = 35;
  localparam longint RECIP   = ((64'd1 << RSH) + PAGE_SIZE - 1) / PAGE_SIZE;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_SPILL, ST_LOAD, ST_ACCESS, ST_RDWAIT, ST_FSCAN, ST_DONE
  } state_t;

  state_t state_r;

  op_t               op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  page_r;
  logic [DATA_W-1:0] val_r;
  logic [FRW-1:0]    vf_r;
  logic [CW-1:0]     cnt_r;
  logic              hit_r;
  logic              wb_r;
  logic              err_r;
  logic [DATA_W-1:0] rd_r;

  logic [PGW-1:0] frame_page_r  [NUM_FRAMES];
  logic           frame_valid_r [NUM_FRAMES];
  logic           frame_dirty_r [NUM_FRAMES];
  logic [FRW-1:0] frame_rank_r  [NUM_FRAMES];
  logic           page_written_r [NPG];

  logic [DATA_W-1:0] frame_mem [FM_DEPTH];
  logic [DATA_W-1:0] back_mem  [BS_DEPTH];
  logic [DATA_W-1:0] fm_rdata_r;
  logic [DATA_W-1:0] bs_rdata_r;

  logic [DATA_W-1:0] out_read_data_r;
  logic              out_valid_r;
  logic              out_was_hit_r;
  logic              out_wrote_back_r;
  logic              out_index_error_r;

  // Page split of the incoming index.
  logic [IDX_W-1:0] in_page;
  assign in_page = IDX_W'((64'(in_byte_index) * 64'(RECIP)) >> RSH);

  logic [OFFW-1:0] off;
  logic [IDX_W-1:0] off_full;
  assign off_full = idx_r - IDX_W'(page_r * PAGE_SIZE);
  assign off      = OFFW'(off_full);

  logic [OFFW-1:0] cnt_lo;
  logic [OFFW-1:0] cnt_prev;
  logic            cnt_end;
  assign cnt_lo   = OFFW'(cnt_r);
  assign cnt_prev = OFFW'(cnt_r - CW'(1));
  assign cnt_end  = (cnt_r == CW'(PAGE_SIZE));

  logic           in_range;
  assign in_range = (32'(idx_r) < 32'(ARRAY_BYTES));

  logic [FMW-1:0] fm_base;
  logic [BSW-1:0] load_base;
  logic [BSW-1:0] spill_base;
  logic [PGW-1:0] cur_page;
  assign cur_page   = PGW'(page_r);
  assign fm_base    = FMW'(vf_r * PAGE_SIZE);
  assign load_base  = BSW'(cur_page * PAGE_SIZE);
  assign spill_base = BSW'(frame_page_r[vf_r] * PAGE_SIZE);

  // Tag match, first matching frame wins.
  logic           hit;
  logic [FRW-1:0] hit_fr;
  logic [FRW-1:0] victim;
  logic [NUM_FRAMES-1:0] rank_zero;
  always_comb begin
    hit    = 1'b0;
    hit_fr = '0;
    victim = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (frame_valid_r[i] && frame_page_r[i] == cur_page) begin
        hit    = 1'b1;
        hit_fr = FRW'(i);
      end
      rank_zero[i] = (frame_rank_r[i] == '0);
      if (rank_zero[i]) begin
        victim = FRW'(i);
      end
    end
  end

  // Memory ports.
  logic              fm_we;
  logic [FMW-1:0]    fm_waddr;
  logic [DATA_W-1:0] fm_wdata;
  logic [FMW-1:0]    fm_raddr;
  logic              bs_we;
  logic [BSW-1:0]    bs_waddr;
  logic [BSW-1:0]    bs_raddr;

  always_comb begin
    fm_raddr = (state_r == ST_SPILL) ? fm_base + FMW'(cnt_lo) : fm_base + FMW'(off);
    fm_we    = 1'b0;
    fm_waddr = fm_base + FMW'(off);
    fm_wdata = val_r;
    if (state_r == ST_LOAD && cnt_r != '0) begin
      fm_we    = 1'b1;
      fm_waddr = fm_base + FMW'(cnt_prev);
      fm_wdata = page_written_r[cur_page] ? bs_rdata_r : '0;
    end else if (state_r == ST_ACCESS && op_r == OP_WRITE) begin
      fm_we = 1'b1;
    end
    bs_raddr = load_base + BSW'(cnt_lo);
    bs_we    = (state_r == ST_SPILL) && (cnt_r != '0);
    bs_waddr = spill_base + BSW'(cnt_prev);
  end

  always_ff @(posedge clk) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= fm_wdata;
    end
    fm_rdata_r <= frame_mem[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (bs_we) begin
      back_mem[bs_waddr] <= fm_rdata_r;
    end
    bs_rdata_r <= back_mem[bs_raddr];
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_was_hit     = out_was_hit_r;
  assign out_wrote_back  = out_wrote_back_r;
  assign out_index_error = out_index_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_page_r[i]  <= '0;
        frame_valid_r[i] <= 1'b0;
        frame_dirty_r[i] <= 1'b0;
        frame_rank_r[i]  <= FRW'(i);
      end
      for (int p = 0; p < NPG; p++) begin
        page_written_r[p] <= 1'b0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            idx_r   <= in_byte_index;
            page_r  <= in_page;
            val_r   <= in_write_value;
            hit_r   <= 1'b0;
            wb_r    <= 1'b0;
            err_r   <= 1'b0;
            rd_r    <= '0;
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          cnt_r <= '0;
          if (op_r == OP_UNUSED) begin
            state_r <= ST_DONE;
          end else if (op_r == OP_FLUSH) begin
            vf_r    <= '0;
            state_r <= ST_FSCAN;
          end else if (!in_range) begin
            err_r   <= 1'b1;
            state_r <= ST_DONE;
          end else if (hit) begin
            hit_r   <= 1'b1;
            vf_r    <= hit_fr;
            state_r <= ST_ACCESS;
          end else begin
            vf_r    <= victim;
            state_r <= (frame_valid_r[victim] && frame_dirty_r[victim]) ? ST_SPILL : ST_LOAD;
          end
        end
        ST_FSCAN: begin
          cnt_r <= '0;
          if (frame_valid_r[vf_r] && frame_dirty_r[vf_r]) begin
            state_r <= ST_SPILL;
          end else if (vf_r == FRW'(NUM_FRAMES - 1)) begin
            state_r <= ST_DONE;
          end else begin
            vf_r <= vf_r + FRW'(1);
          end
        end
        ST_SPILL: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_end) begin
            cnt_r                <= '0;
            wb_r                 <= 1'b1;
            frame_dirty_r[vf_r]  <= 1'b0;
            page_written_r[frame_page_r[vf_r]] <= 1'b1;
            if (op_r == OP_FLUSH) begin
              if (vf_r == FRW'(NUM_FRAMES - 1)) begin
                state_r <= ST_DONE;
              end else begin
                vf_r    <= vf_r + FRW'(1);
                state_r <= ST_FSCAN;
              end
            end else begin
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_end) begin
            frame_page_r[vf_r]  <= cur_page;
            frame_valid_r[vf_r] <= 1'b1;
            frame_dirty_r[vf_r] <= 1'b0;
            state_r             <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          // Make this frame the most recent one.
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (frame_rank_r[i] > frame_rank_r[vf_r]) begin
              frame_rank_r[i] <= frame_rank_r[i] - FRW'(1);
            end
          end
          frame_rank_r[vf_r] <= FRW'(NUM_FRAMES - 1);
          if (op_r == OP_WRITE) begin
            frame_dirty_r[vf_r] <= 1'b1;
            state_r             <= ST_DONE;
          end else begin
            state_r <= ST_RDWAIT;
          end
        end
        ST_RDWAIT: begin
          rd_r    <= fm_rdata_r;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r       <= 1'b1;
            out_read_data_r   <= rd_r;
            out_was_hit_r     <= hit_r;
            out_wrote_back_r  <= wb_r;
            out_index_error_r <= err_r;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Exactly one frame is least recent at all times.
  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(rank_zero))
    else $error("recency ranks lost their single least recent frame");

  // A copy to the backing store only ever starts from a valid dirty frame.
  a_spill_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPILL && cnt_r == '0) |-> (frame_valid_r[vf_r] && frame_dirty_r[vf_r]))
    else $error("spill of a clean or empty frame");

  // A flagged index carries nothing else.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_index_error_r) |->
      (out_read_data_r == '0 && !out_was_hit_r && !out_wrote_back_r))
    else $error("index error result with other fields set");

  // A hit never loads or spills a page.
  a_hit_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP && hit && in_range && (op_r == OP_READ || op_r == OP_WRITE))
      |=> (state_r == ST_ACCESS))
    else $error("hit did not go straight to the frame access");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Paged byte store testbench
// Drives reads, writes, flushes and the unused operation code into the cached byte
// store, predicts each result with a behavioural copy of the frames and the
// backing store, and checks every result transfer against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pbs_pkg::*;

  localparam int PAGE_BYTES  = 16;
  localparam int PAGE_COUNT  = 64;
  localparam int FRAME_COUNT = 4;
  localparam int STORE_BYTES = PAGE_BYTES * PAGE_COUNT;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              was_hit;
    logic              wrote_back;
    logic              index_error;
  } access_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_operation;
  logic [IDX_W-1:0]  in_byte_index;
  logic [DATA_W-1:0] in_write_value;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_read_data;
  logic              out_was_hit;
  logic              out_wrote_back;
  logic              out_index_error;

  paged_byte_store_lru_write_back dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_byte_index  (in_byte_index),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_was_hit    (out_was_hit),
    .out_wrote_back (out_wrote_back),
    .out_index_error(out_index_error)
  );

  // Predicted state of the cache and its backing store.
  logic [DATA_W-1:0] cached_bytes [FRAME_COUNT*PAGE_BYTES];
  logic [5:0]        cached_page  [FRAME_COUNT];
  logic              cached_valid [FRAME_COUNT];
  logic              cached_dirty [FRAME_COUNT];
  int unsigned       recency_rank [FRAME_COUNT];
  logic [DATA_W-1:0] memory_bytes [STORE_BYTES];

  access_result_t pending_results[$];
  int             mismatch_count;
  int             idle_cycles;
  bit             receiver_hold;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Copies a dirty frame back to its page; says whether anything was copied.
  function automatic bit spill_to_memory(int f);
    if (!cached_dirty[f] || !cached_valid[f]) return 1'b0;
    for (int b = 0; b < PAGE_BYTES; b++)
      memory_bytes[cached_page[f]*PAGE_BYTES+b] = cached_bytes[f*PAGE_BYTES+b];
    cached_dirty[f] = 1'b0;
    return 1'b1;
  endfunction

  // Works out the result of one access and updates the predicted state.
  function automatic access_result_t cache_access(op_t op, logic [IDX_W-1:0] idx,
                                                   logic [DATA_W-1:0] value);
    access_result_t res;
    int page;
    int offset;
    int f;
    int old_rank;
    res = '0;
    if (op == OP_FLUSH) begin
      for (int i = 0; i < FRAME_COUNT; i++)
        if (spill_to_memory(i)) res.wrote_back = 1'b1;
      return res;
    end
    if (op == OP_UNUSED) return res;
    if (idx >= STORE_BYTES) begin
      res.index_error = 1'b1;
      return res;
    end
    page   = idx / PAGE_BYTES;
    offset = idx % PAGE_BYTES;
    f = -1;
    for (int i = 0; i < FRAME_COUNT; i++)
      if (f < 0 && cached_valid[i] && cached_page[i] == page) f = i;
    if (f >= 0) begin
      res.was_hit = 1'b1;
    end else begin
      f = 0;
      for (int i = FRAME_COUNT - 1; i >= 0; i--)
        if (recency_rank[i] == 0) f = i;
      res.wrote_back = spill_to_memory(f);
      for (int b = 0; b < PAGE_BYTES; b++)
        cached_bytes[f*PAGE_BYTES+b] = memory_bytes[page*PAGE_BYTES+b];
      cached_page[f]  = page[5:0];
      cached_valid[f] = 1'b1;
      cached_dirty[f] = 1'b0;
    end
    if (op == OP_WRITE) begin
      cached_bytes[f*PAGE_BYTES+offset] = value;
      cached_dirty[f] = 1'b1;
    end else begin
      res.read_data = cached_bytes[f*PAGE_BYTES+offset];
    end
    old_rank = recency_rank[f];
    for (int i = 0; i < FRAME_COUNT; i++)
      if (recency_rank[i] > old_rank) recency_rank[i]--;
    recency_rank[f] = FRAME_COUNT - 1;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Offers one item after a random gap, holding it until it is accepted. The
  // prediction is made at the accepting edge so that results stay in order.
  // Valid is dropped at the next falling edge only when a gap follows.
  task automatic send_access(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value,
                             bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_byte_index  <= idx;
    in_write_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(cache_access(op, idx, value));
  endtask

  // Receiver: random stalls per transfer, plus the long hold on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold) begin
        out_ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!(out_valid && out_ready));
      end
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result transfer");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", out_read_data, want.read_data);
        if (out_was_hit !== want.was_hit)
          report_mismatch("was_hit", out_was_hit, want.was_hit);
        if (out_wrote_back !== want.wrote_back)
          report_mismatch("wrote_back", out_wrote_back, want.wrote_back);
        if (out_index_error !== want.index_error)
          report_mismatch("index_error", out_index_error, want.index_error);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("paged_byte_store_lru_write_back test failed");
      $finish;
    end
  end

  // Extremes of every field, every operation and each special case.
  task automatic test_directed();
    send_access(OP_READ, 10'd0, 8'h00);
    send_access(OP_WRITE, 10'd0, 8'hFF);
    send_access(OP_READ, 10'd0, 8'h00);
    send_access(OP_WRITE, 10'd1023, 8'hA5);
    send_access(OP_READ, 10'd1023, 8'h5A);
    send_access(OP_WRITE, 10'd511, 8'h00);
    send_access(OP_WRITE, 10'd16, 8'h7F);
    send_access(OP_WRITE, 10'd32, 8'h80);
    // Page five evicts a dirty frame.
    send_access(OP_READ, 10'd80, 8'hFF);
    send_access(OP_READ, 10'd0, 8'h00);
    send_access(OP_UNUSED, 10'd1023, 8'hFF);
    send_access(OP_FLUSH, 10'd1023, 8'hFF);
    // Nothing dirty is left, so this flush writes nothing back.
    send_access(OP_FLUSH, 10'd0, 8'h00);
    send_access(OP_READ, 10'd1023, 8'h00);
    send_access(OP_WRITE, 10'd1008, 8'h55);
    send_access(OP_READ, 10'd1008, 8'h00);
  endtask

  // Random traffic, mostly over seven pages, so that hits, misses and evictions mix.
  task automatic test_random(int count);
    int page;
    int sel;
    op_t op;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      op   = sel < 45 ? OP_READ : sel < 90 ? OP_WRITE : sel < 96 ? OP_FLUSH : OP_UNUSED;
      page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGE_COUNT - 1)
                                          : $urandom_range(0, 6) * 9;
      send_access(op, IDX_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)),
                  DATA_W'($urandom));
    end
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_back_pressure();
    receiver_hold = 1'b1;
    fork
      for (int n = 0; n < 8; n++)
        send_access(op_t'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, STORE_BYTES - 1)), DATA_W'($urandom), 1'b1);
      begin
        repeat (300) @(posedge clk);
        receiver_hold = 1'b0;
      end
    join
  endtask

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    receiver_hold  = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_READ;
    in_byte_index  = '0;
    in_write_value = '0;
    for (int i = 0; i < FRAME_COUNT*PAGE_BYTES; i++) cached_bytes[i] = '0;
    for (int i = 0; i < STORE_BYTES; i++) memory_bytes[i] = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      cached_page[i]  = '0;
      cached_valid[i] = 1'b0;
      cached_dirty[i] = 1'b0;
      recency_rank[i] = i;
    end
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_back_pressure();
    test_random(1720);
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("paged_byte_store_lru_write_back test passed");
    else
      $display("paged_byte_store_lru_write_back test failed");
    $finish;
  end

endmodule
